FILE: hw/rtl/rmc_pkg.sv
// Shared types, character codes and constants of the RMC position parser.
// Used by rmc_front, rmc_back and the top level; no dependencies.
package rmc_pkg;

	// parameter defaults
	localparam int unsigned MINUTE_FRAC_DIGITS_DEF = 5;
	localparam int unsigned VALUE_FRAC_DIGITS_DEF  = 3;

	// queue depths
	localparam int unsigned MID_DEPTH = 2;
	localparam int unsigned OUT_DEPTH = 4;

	// character codes
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SOUTH = 8'h53;
	localparam logic [7:0] CH_WEST  = 8'h57;

	// field numbers, the leading tag is field one
	localparam logic [3:0] FLD_FIRST = 4'd1;
	localparam logic [3:0] FLD_LAT   = 4'd4;
	localparam logic [3:0] FLD_NS    = 4'd5;
	localparam logic [3:0] FLD_LON   = 4'd6;
	localparam logic [3:0] FLD_EW    = 4'd7;
	localparam logic [3:0] FLD_SPD   = 4'd8;
	localparam logic [3:0] FLD_CRS   = 4'd9;
	localparam logic [3:0] FLD_MAX   = 4'd15;

	// widths sized for the largest parameter values
	localparam int unsigned ACC_W     = 27;  // minutes, speed: below 1e8
	localparam int unsigned CRS_W     = 24;  // course: below 1e7
	localparam int unsigned LAT_DEG_W = 7;
	localparam int unsigned LON_DEG_W = 10;
	localparam int unsigned P10_W     = 20;  // up to 1e6
	localparam int unsigned E7_W      = 24;
	localparam int unsigned DEG_E7_W  = 34;
	localparam int unsigned X_W       = 30;  // minutes in 1e-7 units, below 1e9
	localparam int unsigned RECIP_W   = 31;
	localparam int unsigned RECIP_SHIFT = 36;
	localparam int unsigned Q_W       = 25;
	localparam int unsigned ANG_W     = 35;
	localparam int unsigned LAT_W     = 31;
	localparam int unsigned SPD_OUT_W = 24;
	localparam int unsigned CRS_OUT_W = 20;

	localparam logic [E7_W-1:0] E7 = 24'd10000000;
	// ceil(2^36 / 60): exact quotient for any value below 2^30
	localparam logic [RECIP_W-1:0] RECIP_60 = 31'd1145324613;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_CONV    = 2'd2
	} rmc_status_t;

	// one closed sentence, front to back
	typedef struct packed {
		logic [3:0]           present;
		logic                 bad;
		logic [1:0]           hemi;     // bit0 south, bit1 west
		logic [LAT_DEG_W-1:0] lat_deg;
		logic [ACC_W-1:0]     lat_min;
		logic [2:0]           lat_kept;
		logic [LON_DEG_W-1:0] lon_deg;
		logic [ACC_W-1:0]     lon_min;
		logic [2:0]           lon_kept;
		logic [ACC_W-1:0]     spd;
		logic [2:0]           spd_kept;
		logic [CRS_W-1:0]     crs;
		logic [2:0]           crs_kept;
	} rmc_rec_t;

	typedef struct packed {
		rmc_status_t                 status;
		logic signed [LAT_W-1:0]     lat;
		logic signed [ANG_W-1:0]     lon;
		logic [SPD_OUT_W-1:0]        spd;
		logic [CRS_OUT_W-1:0]        crs;
	} rmc_res_t;

	function automatic logic [P10_W-1:0] pow10(input logic [2:0] n);
		logic [P10_W-1:0] r;
		unique case (n)
			3'd0:    r = 20'd1;
			3'd1:    r = 20'd10;
			3'd2:    r = 20'd100;
			3'd3:    r = 20'd1000;
			3'd4:    r = 20'd10000;
			3'd5:    r = 20'd100000;
			3'd6:    r = 20'd1000000;
			default: r = 20'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/rmc_fifo.sv
// Small register queue with full and empty flags.
// Generic; no package dependency.
module rmc_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/rmc_front.sv
// Byte parser: splits the sentence at commas and accumulates the fields.
// Depends on rmc_pkg; emits one rmc_rec_t per sentence.
module rmc_front #(
	parameter int unsigned MINUTE_FRAC_DIGITS = rmc_pkg::MINUTE_FRAC_DIGITS_DEF,
	parameter int unsigned VALUE_FRAC_DIGITS  = rmc_pkg::VALUE_FRAC_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_in,
	input  logic              last_char,
	output logic              rec_push,
	output rmc_pkg::rmc_rec_t rec
);

	localparam int unsigned ACC_W = rmc_pkg::ACC_W;
	localparam int unsigned CRS_W = rmc_pkg::CRS_W;
	localparam logic [2:0] MF = 3'(MINUTE_FRAC_DIGITS);
	localparam logic [2:0] VF = 3'(VALUE_FRAC_DIGITS);

	logic [3:0] field_q, field_n;
	logic [4:0] pos_q, pos_n;
	logic       dot_q, dot_n;
	logic [2:0] icnt_q, icnt_n, fcnt_q, fcnt_n;
	logic [rmc_pkg::LAT_DEG_W-1:0] lat_deg_q, lat_deg_n;
	logic [rmc_pkg::LON_DEG_W-1:0] lon_deg_q, lon_deg_n;
	logic [ACC_W-1:0] lat_min_q, lat_min_n, lon_min_q, lon_min_n, spd_q, spd_n;
	logic [CRS_W-1:0] crs_q, crs_n;
	logic [2:0] lat_kept_q, lat_kept_n, lon_kept_q, lon_kept_n;
	logic [2:0] spd_kept_q, spd_kept_n, crs_kept_q, crs_kept_n;
	logic [1:0] hemi_q, hemi_n;
	logic [3:0] present_q, present_n;
	logic       bad_q, bad_n;

	logic             is_digit, is_comma, is_dot;
	logic [3:0]       digit;
	logic             num_act, deg_act, acc_wr;
	logic [ACC_W-1:0] acc_cur, acc_mac;
	logic [2:0]       int_lim, frac_lim;
	logic [rmc_pkg::LON_DEG_W-1:0] deg_cur, deg_mac;
	logic [2:0]       kept;
	logic             no_digit;

	assign is_digit = (char_in >= rmc_pkg::CH_ZERO) && (char_in <= rmc_pkg::CH_NINE);
	assign is_comma = (char_in == rmc_pkg::CH_COMMA);
	assign is_dot   = (char_in == rmc_pkg::CH_DOT);
	assign digit    = char_in[3:0];

	always_comb begin
		field_n    = field_q;
		pos_n      = pos_q;
		dot_n      = dot_q;
		icnt_n     = icnt_q;
		fcnt_n     = fcnt_q;
		lat_deg_n  = lat_deg_q;
		lon_deg_n  = lon_deg_q;
		lat_min_n  = lat_min_q;
		lon_min_n  = lon_min_q;
		spd_n      = spd_q;
		crs_n      = crs_q;
		lat_kept_n = lat_kept_q;
		lon_kept_n = lon_kept_q;
		spd_kept_n = spd_kept_q;
		crs_kept_n = crs_kept_q;
		hemi_n     = hemi_q;
		present_n  = present_q;
		bad_n      = bad_q;
		acc_wr     = 1'b0;

		// number lane of the current field
		num_act  = 1'b0;
		deg_act  = 1'b0;
		acc_cur  = '0;
		int_lim  = 3'd0;
		frac_lim = 3'd0;
		deg_cur  = '0;
		unique case (field_q)
			rmc_pkg::FLD_LAT: begin
				num_act  = (pos_q >= 5'd2);
				deg_act  = !num_act;
				acc_cur  = lat_min_q;
				int_lim  = 3'd2;
				frac_lim = MF;
				deg_cur  = 10'(lat_deg_q);
			end
			rmc_pkg::FLD_LON: begin
				num_act  = (pos_q >= 5'd3);
				deg_act  = !num_act;
				acc_cur  = lon_min_q;
				int_lim  = 3'd2;
				frac_lim = MF;
				deg_cur  = lon_deg_q;
			end
			rmc_pkg::FLD_SPD: begin
				num_act  = 1'b1;
				acc_cur  = spd_q;
				int_lim  = 3'd4;
				frac_lim = VF;
			end
			rmc_pkg::FLD_CRS: begin
				num_act  = 1'b1;
				acc_cur  = ACC_W'(crs_q);
				int_lim  = 3'd3;
				frac_lim = VF;
			end
			default: begin
			end
		endcase
		acc_mac = ACC_W'(acc_cur * ACC_W'(10)) + ACC_W'(digit);
		deg_mac = 10'(deg_cur * 10'd10) + 10'(digit);

		if (!is_comma) begin
			if (field_q >= rmc_pkg::FLD_LAT && field_q <= rmc_pkg::FLD_EW) begin
				present_n[2'(field_q - rmc_pkg::FLD_LAT)] = 1'b1;
			end
			if (num_act) begin
				if (is_digit) begin
					if (!dot_q) begin
						if (icnt_q >= int_lim) begin
							bad_n = 1'b1;
						end else begin
							acc_wr = 1'b1;
						end
						icnt_n = (icnt_q < 3'd7) ? icnt_q + 1'b1 : icnt_q;
					end else begin
						acc_wr = (fcnt_q < frac_lim);
						fcnt_n = (fcnt_q < 3'd7) ? fcnt_q + 1'b1 : fcnt_q;
					end
				end else if (is_dot) begin
					if (dot_q) begin
						bad_n = 1'b1;
					end
					dot_n = 1'b1;
				end else begin
					bad_n = 1'b1;
				end
			end
			if (deg_act) begin
				if (!is_digit) begin
					bad_n = 1'b1;
				end else if (field_q == rmc_pkg::FLD_LAT) begin
					lat_deg_n = rmc_pkg::LAT_DEG_W'(deg_mac);
				end else begin
					lon_deg_n = deg_mac;
				end
			end
			if (acc_wr) begin
				unique case (field_q)
					rmc_pkg::FLD_LAT: lat_min_n = acc_mac;
					rmc_pkg::FLD_LON: lon_min_n = acc_mac;
					rmc_pkg::FLD_SPD: spd_n = acc_mac;
					default:          crs_n = CRS_W'(acc_mac);
				endcase
			end
			// hemisphere counts only when the field is exactly one letter
			if (field_q == rmc_pkg::FLD_NS) begin
				hemi_n[0] = (pos_q == 5'd0) && (char_in == rmc_pkg::CH_SOUTH);
			end
			if (field_q == rmc_pkg::FLD_EW) begin
				hemi_n[1] = (pos_q == 5'd0) && (char_in == rmc_pkg::CH_WEST);
			end
			pos_n = (pos_q < 5'd31) ? pos_q + 1'b1 : pos_q;
		end

		// field close: on a comma the counters are unchanged, on a final
		// non-comma byte they already include that byte
		kept     = (fcnt_n < frac_lim) ? fcnt_n : frac_lim;
		no_digit = (icnt_n == 3'd0) && (fcnt_n == 3'd0);
		if (is_comma || last_char) begin
			if (pos_n != 5'd0 && num_act) begin
				bad_n = bad_n || no_digit;
				unique case (field_q)
					rmc_pkg::FLD_LAT: lat_kept_n = kept;
					rmc_pkg::FLD_LON: lon_kept_n = kept;
					rmc_pkg::FLD_SPD: spd_kept_n = kept;
					default:          crs_kept_n = kept;
				endcase
			end else if (pos_n != 5'd0 && deg_act) begin
				// degree digits only, minute part empty
				bad_n = 1'b1;
			end
			pos_n  = '0;
			dot_n  = 1'b0;
			icnt_n = '0;
			fcnt_n = '0;
		end
		if (is_comma && field_q < rmc_pkg::FLD_MAX) begin
			field_n = field_q + 1'b1;
		end
	end

	assign rec_push = accept && last_char;

	always_comb begin
		rec.present  = present_n;
		rec.bad      = bad_n;
		rec.hemi     = hemi_n;
		rec.lat_deg  = lat_deg_n;
		rec.lat_min  = lat_min_n;
		rec.lat_kept = lat_kept_n;
		rec.lon_deg  = lon_deg_n;
		rec.lon_min  = lon_min_n;
		rec.lon_kept = lon_kept_n;
		rec.spd      = spd_n;
		rec.spd_kept = spd_kept_n;
		rec.crs      = crs_n;
		rec.crs_kept = crs_kept_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q    <= rmc_pkg::FLD_FIRST;
			pos_q      <= '0;
			dot_q      <= 1'b0;
			icnt_q     <= '0;
			fcnt_q     <= '0;
			lat_deg_q  <= '0;
			lon_deg_q  <= '0;
			lat_min_q  <= '0;
			lon_min_q  <= '0;
			spd_q      <= '0;
			crs_q      <= '0;
			lat_kept_q <= '0;
			lon_kept_q <= '0;
			spd_kept_q <= '0;
			crs_kept_q <= '0;
			hemi_q     <= '0;
			present_q  <= '0;
			bad_q      <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				field_q    <= rmc_pkg::FLD_FIRST;
				pos_q      <= '0;
				dot_q      <= 1'b0;
				icnt_q     <= '0;
				fcnt_q     <= '0;
				lat_deg_q  <= '0;
				lon_deg_q  <= '0;
				lat_min_q  <= '0;
				lon_min_q  <= '0;
				spd_q      <= '0;
				crs_q      <= '0;
				lat_kept_q <= '0;
				lon_kept_q <= '0;
				spd_kept_q <= '0;
				crs_kept_q <= '0;
				hemi_q     <= '0;
				present_q  <= '0;
				bad_q      <= 1'b0;
			end else begin
				field_q    <= field_n;
				pos_q      <= pos_n;
				dot_q      <= dot_n;
				icnt_q     <= icnt_n;
				fcnt_q     <= fcnt_n;
				lat_deg_q  <= lat_deg_n;
				lon_deg_q  <= lon_deg_n;
				lat_min_q  <= lat_min_n;
				lon_min_q  <= lon_min_n;
				spd_q      <= spd_n;
				crs_q      <= crs_n;
				lat_kept_q <= lat_kept_n;
				lon_kept_q <= lon_kept_n;
				spd_kept_q <= spd_kept_n;
				crs_kept_q <= crs_kept_n;
				hemi_q     <= hemi_n;
				present_q  <= present_n;
				bad_q      <= bad_n;
			end
		end
	end

endmodule

FILE: hw/rtl/rmc_back.sv
// Conversion pipeline: scales fractions, turns minutes into 1e-7 degree,
// applies signs and saturation. Depends on rmc_pkg.
module rmc_back #(
	parameter int unsigned MINUTE_FRAC_DIGITS = rmc_pkg::MINUTE_FRAC_DIGITS_DEF,
	parameter int unsigned VALUE_FRAC_DIGITS  = rmc_pkg::VALUE_FRAC_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rmc_pkg::rmc_rec_t in_rec,
	output logic              in_pop,
	input  logic              out_full,
	output logic              out_push,
	output rmc_pkg::rmc_res_t out_res
);

	localparam int unsigned ACC_W = rmc_pkg::ACC_W;
	localparam int unsigned CRS_W = rmc_pkg::CRS_W;
	localparam int unsigned P10_W = rmc_pkg::P10_W;
	localparam int unsigned X_W   = rmc_pkg::X_W;
	localparam int unsigned Q_W   = rmc_pkg::Q_W;
	localparam int unsigned ANG_W = rmc_pkg::ANG_W;
	localparam int unsigned DE_W  = rmc_pkg::DEG_E7_W;
	localparam logic [2:0] MF = 3'(MINUTE_FRAC_DIGITS);
	localparam logic [2:0] VF = 3'(VALUE_FRAC_DIGITS);
	localparam logic [P10_W-1:0] MIN_SCALE =
		rmc_pkg::pow10(3'(7 - MINUTE_FRAC_DIGITS));
	localparam int unsigned PA_W = ACC_W + P10_W;
	localparam int unsigned PR_W = X_W + rmc_pkg::RECIP_W;

	logic en;

	// stage 1: fraction padding and degree scaling
	logic [PA_W-1:0] lat_ms_p, lon_ms_p, spd_p, crs_p;
	logic [DE_W-1:0] lat_de_p, lon_de_p;
	rmc_pkg::rmc_status_t st_in;

	logic                 v_s1;
	rmc_pkg::rmc_status_t st_s1;
	logic [1:0]           neg_s1;
	logic [DE_W-1:0]      lat_de_s1, lon_de_s1;
	logic [ACC_W-1:0]     lat_ms_s1, lon_ms_s1, spd_s1;
	logic [CRS_W-1:0]     crs_s1;

	// stage 2: minutes to 1e-7 units, signed degree part, saturation
	logic [PA_W-1:0] lat_x_p, lon_x_p;

	logic                        v_s2;
	rmc_pkg::rmc_status_t        st_s2;
	logic [1:0]                  neg_s2;
	logic signed [ANG_W-1:0]     lat_dn_s2, lon_dn_s2;
	logic [X_W-1:0]              lat_x_s2, lon_x_s2;
	logic [rmc_pkg::SPD_OUT_W-1:0] spd_s2;
	logic [rmc_pkg::CRS_OUT_W-1:0] crs_s2;

	// stage 3: divide by sixty through the reciprocal
	logic [PR_W-1:0] lat_qp, lon_qp;

	logic                        v_s3;
	rmc_pkg::rmc_status_t        st_s3;
	logic [1:0]                  neg_s3;
	logic signed [ANG_W-1:0]     lat_dn_s3, lon_dn_s3;
	logic [Q_W-1:0]              lat_q_s3, lon_q_s3;
	logic [rmc_pkg::SPD_OUT_W-1:0] spd_s3;
	logic [rmc_pkg::CRS_OUT_W-1:0] crs_s3;

	logic signed [ANG_W-1:0] lat_ang, lon_ang, lat_qs, lon_qs;

	assign en     = !out_full;
	assign in_pop = en && in_valid;

	always_comb begin
		lat_ms_p = PA_W'(in_rec.lat_min) * PA_W'(rmc_pkg::pow10(MF - in_rec.lat_kept));
		lon_ms_p = PA_W'(in_rec.lon_min) * PA_W'(rmc_pkg::pow10(MF - in_rec.lon_kept));
		spd_p    = PA_W'(in_rec.spd) * PA_W'(rmc_pkg::pow10(VF - in_rec.spd_kept));
		crs_p    = PA_W'(in_rec.crs) * PA_W'(rmc_pkg::pow10(VF - in_rec.crs_kept));
		lat_de_p = DE_W'(in_rec.lat_deg) * DE_W'(rmc_pkg::E7);
		lon_de_p = DE_W'(in_rec.lon_deg) * DE_W'(rmc_pkg::E7);
		// a missing field wins over a conversion error
		if (in_rec.present != 4'hF) begin
			st_in = rmc_pkg::ST_MISSING;
		end else if (in_rec.bad) begin
			st_in = rmc_pkg::ST_CONV;
		end else begin
			st_in = rmc_pkg::ST_OK;
		end
	end

	assign lat_x_p = PA_W'(lat_ms_s1) * PA_W'(MIN_SCALE);
	assign lon_x_p = PA_W'(lon_ms_s1) * PA_W'(MIN_SCALE);
	assign lat_qp  = PR_W'(lat_x_s2) * PR_W'(rmc_pkg::RECIP_60);
	assign lon_qp  = PR_W'(lon_x_s2) * PR_W'(rmc_pkg::RECIP_60);

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1     <= st_in;
			neg_s1    <= in_rec.hemi;
			lat_de_s1 <= lat_de_p;
			lon_de_s1 <= lon_de_p;
			lat_ms_s1 <= ACC_W'(lat_ms_p);
			lon_ms_s1 <= ACC_W'(lon_ms_p);
			spd_s1    <= ACC_W'(spd_p);
			crs_s1    <= CRS_W'(crs_p);

			st_s2     <= st_s1;
			neg_s2    <= neg_s1;
			lat_dn_s2 <= neg_s1[0] ? -$signed(ANG_W'(lat_de_s1)) : $signed(ANG_W'(lat_de_s1));
			lon_dn_s2 <= neg_s1[1] ? -$signed(ANG_W'(lon_de_s1)) : $signed(ANG_W'(lon_de_s1));
			lat_x_s2  <= X_W'(lat_x_p);
			lon_x_s2  <= X_W'(lon_x_p);
			spd_s2    <= (spd_s1 > ACC_W'({rmc_pkg::SPD_OUT_W{1'b1}})) ?
				{rmc_pkg::SPD_OUT_W{1'b1}} : rmc_pkg::SPD_OUT_W'(spd_s1);
			crs_s2    <= (crs_s1 > CRS_W'({rmc_pkg::CRS_OUT_W{1'b1}})) ?
				{rmc_pkg::CRS_OUT_W{1'b1}} : rmc_pkg::CRS_OUT_W'(crs_s1);

			st_s3     <= st_s2;
			neg_s3    <= neg_s2;
			lat_dn_s3 <= lat_dn_s2;
			lon_dn_s3 <= lon_dn_s2;
			lat_q_s3  <= lat_qp[rmc_pkg::RECIP_SHIFT +: Q_W];
			lon_q_s3  <= lon_qp[rmc_pkg::RECIP_SHIFT +: Q_W];
			spd_s3    <= spd_s2;
			crs_s3    <= crs_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// -(deg + q) = (-deg) - q, so one add or subtract
	assign lat_qs  = $signed(ANG_W'(lat_q_s3));
	assign lon_qs  = $signed(ANG_W'(lon_q_s3));
	assign lat_ang = neg_s3[0] ? lat_dn_s3 - lat_qs : lat_dn_s3 + lat_qs;
	assign lon_ang = neg_s3[1] ? lon_dn_s3 - lon_qs : lon_dn_s3 + lon_qs;

	assign out_push = v_s3 && en;

	always_comb begin
		out_res.status = st_s3;
		if (st_s3 == rmc_pkg::ST_OK) begin
			out_res.lat = lat_ang[rmc_pkg::LAT_W-1:0];
			out_res.lon = lon_ang;
			out_res.spd = spd_s3;
			out_res.crs = crs_s3;
		end else begin
			out_res.lat = '0;
			out_res.lon = '0;
			out_res.spd = '0;
			out_res.crs = '0;
		end
	end

endmodule

FILE: hw/rtl/rmc_sentence_position_parser.sv
// Top level of the RMC sentence position parser.
// Depends on rmc_pkg, rmc_front, rmc_fifo and rmc_back.
//
// Usage
//   Input side is a queue write port: a byte transfers at a rising edge with
//   push high and full low. char_in carries one ASCII byte of the sentence,
//   last_char marks its final byte. Fields are split at commas, the tag is
//   field one; fields 4..9 give latitude, N/S, longitude, E/W, speed, course.
//   Result side is a queue read port: while empty is low the oldest result
//   sits on status and the value ports, and it transfers when pop is high.
//   One result comes out per sentence; the transfer of the marked byte closes it.
//
// Timing
//   One byte per cycle while full stays low; the byte parser closes
//   fields in the same cycle it sees the comma or the final byte. The
//   sentence record crosses a two-entry queue into a three-stage
//   conversion pipeline (fraction padding, scaling to 1e-7 units, multiply
//   by the reciprocal of sixty) and lands in a four-entry result queue;
//   empty drops once the record has been written there.
//   A stalled reader holds the pipeline once the result queue fills; the
//   middle queue then fills and full rises, holding off new bytes.
//
// Reset
//   arst_n clears the parser to field one with all values zero, and empties
//   both queues and the pipeline.
module rmc_sentence_position_parser #(
	parameter int unsigned MINUTE_FRAC_DIGITS = rmc_pkg::MINUTE_FRAC_DIGITS_DEF,
	parameter int unsigned VALUE_FRAC_DIGITS  = rmc_pkg::VALUE_FRAC_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         char_in,
	input  logic               last_char,
	input  logic               pop,
	output logic               empty,
	output logic [1:0]         status,
	output logic signed [30:0] latitude_e7,
	output logic signed [34:0] longitude_e7,
	output logic [23:0]        speed_milliknots,
	output logic [19:0]        course_millideg
);

	localparam int unsigned REC_W = $bits(rmc_pkg::rmc_rec_t);
	localparam int unsigned RES_W = $bits(rmc_pkg::rmc_res_t);

	logic              accept;
	logic              rec_push;
	rmc_pkg::rmc_rec_t rec_front;
	logic [REC_W-1:0]  mid_rd;
	rmc_pkg::rmc_rec_t rec_head;
	logic              mid_empty;
	logic              mid_pop;
	logic              res_full;
	logic              res_push;
	rmc_pkg::rmc_res_t res_back;
	logic [RES_W-1:0]  res_rd;
	rmc_pkg::rmc_res_t res_head;

	// byte transfer
	assign accept = push && !full;

	rmc_front #(
		.MINUTE_FRAC_DIGITS (MINUTE_FRAC_DIGITS),
		.VALUE_FRAC_DIGITS  (VALUE_FRAC_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_in   (char_in),
		.last_char (last_char),
		.rec_push  (rec_push),
		.rec       (rec_front)
	);

	// decouples the parser from the conversion pipeline
	rmc_fifo #(
		.WIDTH (REC_W),
		.DEPTH (rmc_pkg::MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (rec_push),
		.wr_data (rec_front),
		.pop     (mid_pop),
		.rd_data (mid_rd),
		.full    (full),
		.empty   (mid_empty)
	);

	assign rec_head = rmc_pkg::rmc_rec_t'(mid_rd);

	rmc_back #(
		.MINUTE_FRAC_DIGITS (MINUTE_FRAC_DIGITS),
		.VALUE_FRAC_DIGITS  (VALUE_FRAC_DIGITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!mid_empty),
		.in_rec   (rec_head),
		.in_pop   (mid_pop),
		.out_full (res_full),
		.out_push (res_push),
		.out_res  (res_back)
	);

	// result queue, the visible read port
	rmc_fifo #(
		.WIDTH (RES_W),
		.DEPTH (rmc_pkg::OUT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_back),
		.pop     (pop),
		.rd_data (res_rd),
		.full    (res_full),
		.empty   (empty)
	);

	assign res_head         = rmc_pkg::rmc_res_t'(res_rd);
	assign status           = res_head.status;
	assign latitude_e7      = res_head.lat;
	assign longitude_e7     = res_head.lon;
	assign speed_milliknots = res_head.spd;
	assign course_millideg  = res_head.crs;

	// pipeline never writes into a full result queue
	a_no_res_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result written while result queue full");

	// a closed sentence is queued for conversion right after its last byte
	a_rec_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_char) |=> !mid_empty)
		else $error("sentence record lost after final byte");

	// values are zero whenever the status is not ok
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != rmc_pkg::ST_OK) |->
		(latitude_e7 == '0 && longitude_e7 == '0 &&
		 speed_milliknots == '0 && course_millideg == '0))
		else $error("nonzero value with error status");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for rmc_sentence_position_parser: RMC sentences byte by byte,
// with a position fix predicted per sentence and compared with each result transfer.
// Depends on rmc_pkg and the parser RTL only.
`timescale 1ns / 1ps

module testbench;
	import rmc_pkg::*;

	localparam int unsigned MIN_FRAC       = MINUTE_FRAC_DIGITS_DEF;
	localparam int unsigned VAL_FRAC       = VALUE_FRAC_DIGITS_DEF;
	localparam int unsigned LAT_DEG_DIGITS = 2;
	localparam int unsigned LON_DEG_DIGITS = 3;
	localparam int unsigned MIN_INT_DIGITS = 2;
	localparam int unsigned SPD_INT_DIGITS = 4;
	localparam int unsigned CRS_INT_DIGITS = 3;
	localparam int unsigned MIN_PER_DEG    = 60;
	localparam int unsigned POS_MAX        = 31;
	localparam int unsigned CNT_MAX        = 7;
	localparam int unsigned HOLD_CYCLES    = 500;   // receiver hold-off in the pressure phase
	localparam int unsigned TAIL_CYCLES    = 40;    // settling margin for the pipeline and both queues
	localparam int unsigned LIMIT_CYCLES   = 200000;
	localparam int unsigned RAND_FIXES     = 3;     // sentences or bursts per random phase

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} nmea_byte_t;

	typedef struct packed {
		rmc_status_t status;
		logic [30:0] lat;
		logic [34:0] lon;
		logic [23:0] spd;
		logic [19:0] crs;
	} fix_t;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] char_in = 8'h00;
	logic last_char = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic [1:0] status;
	logic signed [30:0] latitude_e7;
	logic signed [34:0] longitude_e7;
	logic [23:0] speed_milliknots;
	logic [19:0] course_millideg;

	// bytes waiting to be offered, and fixes waiting to come out
	nmea_byte_t sentence_bytes[$];
	fix_t expected_fixes[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	// parser image: field counters plus the accumulated sentence values
	logic [3:0] p_field;
	int unsigned p_pos, p_int_cnt, p_frac_cnt;
	bit p_dot;
	longint unsigned lat_deg, lat_min, lon_deg, lon_min, spd_acc, crs_acc;
	bit hemi_s, hemi_w, bad_num;
	bit [3:0] seen_fields;

	rmc_sentence_position_parser #(
		.MINUTE_FRAC_DIGITS(MIN_FRAC),
		.VALUE_FRAC_DIGITS(VAL_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_in(char_in),
		.last_char(last_char),
		.pop(pop),
		.empty(empty),
		.status(status),
		.latitude_e7(latitude_e7),
		.longitude_e7(longitude_e7),
		.speed_milliknots(speed_milliknots),
		.course_millideg(course_millideg)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	function automatic longint unsigned ten_pow(int unsigned n);
		longint unsigned r;
		int unsigned i;
		r = 1;
		for (i = 0; i < n; i++)
			r = r * 10;
		return r;
	endfunction

	function automatic bit is_digit(logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic void clear_counters();
		p_pos = 0;
		p_dot = 1'b0;
		p_int_cnt = 0;
		p_frac_cnt = 0;
	endfunction

	function automatic void clear_parser();
		p_field = FLD_FIRST;
		clear_counters();
		lat_deg = 0;
		lat_min = 0;
		lon_deg = 0;
		lon_min = 0;
		spd_acc = 0;
		crs_acc = 0;
		hemi_s = 1'b0;
		hemi_w = 1'b0;
		seen_fields = '0;
		bad_num = 1'b0;
	endfunction

	// Digit or dot of a decimal number; integer digits past int_lim are an
	// error, fraction digits past frac_lim are dropped.
	function automatic longint unsigned fold_number(longint unsigned acc, logic [7:0] c,
			int unsigned int_lim, int unsigned frac_lim);
		longint unsigned next;
		next = acc;
		if (is_digit(c)) begin
			if (!p_dot) begin
				if (p_int_cnt >= int_lim)
					bad_num = 1'b1;
				else
					next = acc * 10 + (c - CH_ZERO);
				if (p_int_cnt < CNT_MAX)
					p_int_cnt = p_int_cnt + 1;
			end else begin
				if (p_frac_cnt < frac_lim)
					next = acc * 10 + (c - CH_ZERO);
				if (p_frac_cnt < CNT_MAX)
					p_frac_cnt = p_frac_cnt + 1;
			end
		end else if (c == CH_DOT) begin
			if (p_dot)
				bad_num = 1'b1;
			p_dot = 1'b1;
		end else begin
			bad_num = 1'b1;
		end
		return next;
	endfunction

	// closing a number needs a digit somewhere; missing fraction digits are zeros
	function automatic longint unsigned pad_number(longint unsigned acc, int unsigned frac_lim);
		int unsigned kept;
		kept = (p_frac_cnt < frac_lim) ? p_frac_cnt : frac_lim;
		if (p_int_cnt == 0 && p_frac_cnt == 0)
			bad_num = 1'b1;
		return acc * ten_pow(frac_lim - kept);
	endfunction

	function automatic void close_field_value();
		if (p_pos != 0) begin
			case (p_field)
				FLD_LAT: lat_min = pad_number(lat_min, MIN_FRAC);
				FLD_LON: lon_min = pad_number(lon_min, MIN_FRAC);
				FLD_SPD: spd_acc = pad_number(spd_acc, VAL_FRAC);
				FLD_CRS: crs_acc = pad_number(crs_acc, VAL_FRAC);
				default: ;
			endcase
		end
		clear_counters();
	endfunction

	function automatic void take_char(logic [7:0] c);
		if (p_field >= FLD_LAT && p_field <= FLD_EW)
			seen_fields[p_field - FLD_LAT] = 1'b1;
		case (p_field)
			FLD_LAT: begin
				if (p_pos < LAT_DEG_DIGITS) begin
					if (is_digit(c))
						lat_deg = lat_deg * 10 + (c - CH_ZERO);
					else
						bad_num = 1'b1;
				end else begin
					lat_min = fold_number(lat_min, c, MIN_INT_DIGITS, MIN_FRAC);
				end
			end
			FLD_LON: begin
				if (p_pos < LON_DEG_DIGITS) begin
					if (is_digit(c))
						lon_deg = lon_deg * 10 + (c - CH_ZERO);
					else
						bad_num = 1'b1;
				end else begin
					lon_min = fold_number(lon_min, c, MIN_INT_DIGITS, MIN_FRAC);
				end
			end
			// only a field that is exactly S or W flips the sign
			FLD_NS: hemi_s = (p_pos == 0 && c == CH_SOUTH);
			FLD_EW: hemi_w = (p_pos == 0 && c == CH_WEST);
			FLD_SPD: spd_acc = fold_number(spd_acc, c, SPD_INT_DIGITS, VAL_FRAC);
			FLD_CRS: crs_acc = fold_number(crs_acc, c, CRS_INT_DIGITS, VAL_FRAC);
			default: ;
		endcase
		if (p_pos < POS_MAX)
			p_pos = p_pos + 1;
	endfunction

	function automatic fix_t sentence_fix();
		fix_t f;
		longint unsigned a;
		f = '0;
		// a missing field outranks a conversion error
		if (seen_fields != 4'hF) begin
			f.status = ST_MISSING;
		end else if (bad_num) begin
			f.status = ST_CONV;
		end else begin
			f.status = ST_OK;
			a = lat_deg * E7 + lat_min * ten_pow(7 - MIN_FRAC) / MIN_PER_DEG;
			if (hemi_s)
				a = 0 - a;
			f.lat = a[30:0];
			a = lon_deg * E7 + lon_min * ten_pow(7 - MIN_FRAC) / MIN_PER_DEG;
			if (hemi_w)
				a = 0 - a;
			f.lon = a[34:0];
			f.spd = (spd_acc > 64'hFF_FFFF) ? '1 : spd_acc[23:0];
			f.crs = (crs_acc > 64'hF_FFFF) ? '1 : crs_acc[19:0];
		end
		return f;
	endfunction

	// one accepted byte; the marked last byte closes the sentence into a fix
	function automatic void parse_byte(logic [7:0] c, logic last);
		if (c == CH_COMMA) begin
			close_field_value();
			if (p_field < FLD_MAX)
				p_field = p_field + 1;
		end else begin
			take_char(c);
		end
		if (last) begin
			close_field_value();
			expected_fixes.push_back(sentence_fix());
			clear_parser();
		end
	endfunction

	// ---------------------------------------------------------------
	// Driver: offers the front byte, holds it until the transfer.
	// The transfer is seen on the pre-edge values of push and full.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				parse_byte(char_in, last_char);
				void'(sentence_bytes.pop_front());
			end
			// a byte still waiting on full keeps push high untouched
			if (!(push && full)) begin
				if (sentence_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					push <= 1'b1;
					char_in <= sentence_bytes[0].ch;
					last_char <= sentence_bytes[0].last;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Long receiver hold-off, counted in cycles when the stimulus asks
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_requests) begin
				hold_seen <= hold_requests;
				hold_left <= HOLD_CYCLES;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: checks each result transfer against the oldest fix.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		fix_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_fixes.size() == 0) begin
					$error("result transfer with no sentence pending: status %0d", status);
					error_count++;
				end else begin
					want = expected_fixes.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						error_count++;
					end
					if (latitude_e7 !== want.lat) begin
						$error("latitude_e7: expected %0d, actual %0d",
							$signed(want.lat), latitude_e7);
						error_count++;
					end
					if (longitude_e7 !== want.lon) begin
						$error("longitude_e7: expected %0d, actual %0d",
							$signed(want.lon), longitude_e7);
						error_count++;
					end
					if (speed_milliknots !== want.spd) begin
						$error("speed_milliknots: expected %0d, actual %0d",
							want.spd, speed_milliknots);
						error_count++;
					end
					if (course_millideg !== want.crs) begin
						$error("course_millideg: expected %0d, actual %0d",
							want.crs, course_millideg);
						error_count++;
					end
				end
			end
			if (hold_seen != hold_requests || hold_left != 0) begin
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------

	function automatic string digit_run(int unsigned n);
		string s;
		int unsigned i;
		s = "";
		for (i = 0; i < n; i++)
			s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		return s;
	endfunction

	// ddmm.m or dddmm.m, mostly two minute digits, fraction length varied
	// past the kept digits
	function automatic string angle_text(int unsigned deg_n);
		string s;
		int unsigned n_int;
		n_int = ($urandom_range(0, 7) != 0) ? MIN_INT_DIGITS : $urandom_range(0, 3);
		s = {digit_run(deg_n), digit_run(n_int)};
		if ($urandom_range(0, 5) != 0)
			s = {s, ".", digit_run($urandom_range(0, 7))};
		return s;
	endfunction

	function automatic string value_text(int unsigned int_lim);
		string s;
		int unsigned n_int;
		if ($urandom_range(0, 5) == 0)
			return "";
		n_int = ($urandom_range(0, 9) == 0) ? int_lim + 1 : $urandom_range(0, int_lim);
		s = digit_run(n_int);
		if ($urandom_range(0, 3) != 0)
			s = {s, ".", digit_run($urandom_range(0, 5))};
		return s;
	endfunction

	function automatic string hemi_text(string plain, string flip);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return plain;
			4, 5, 6, 7: return flip;
			8: return "";
			default: return {flip, flip};
		endcase
	endfunction

	// short leading fields keep the byte count down; the tag shows up now and then
	function automatic string random_sentence();
		string s;
		s = ($urandom_range(0, 3) == 0) ? "$GPRMC,1,A," : ",,,";
		s = {s, angle_text(LAT_DEG_DIGITS), ",", hemi_text("N", "S"), ",",
			angle_text(LON_DEG_DIGITS), ",", hemi_text("E", "W"), ",",
			value_text(SPD_INT_DIGITS), ",", value_text(CRS_INT_DIGITS)};
		if ($urandom_range(0, 7) == 0)
			s = {s, ",0,,,A*", $sformatf("%02X", $urandom_range(0, 255))};
		return s;
	endfunction

	function automatic void queue_byte(logic [7:0] c, logic last);
		sentence_bytes.push_back('{c, last});
	endfunction

	function automatic void queue_text(string s);
		int unsigned i;
		for (i = 0; i < s.len(); i++)
			queue_byte(s[i], i == s.len() - 1);
	endfunction

	// a short burst of arbitrary bytes, closed by its last one
	function automatic void queue_noise();
		int unsigned n, i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++)
			queue_byte($urandom_range(0, 255), i == n - 1);
	endfunction

	// well-formed sentences mixed with noise bursts; some sentences carry
	// one corrupted byte, some are cut short
	function automatic void queue_random(int unsigned n_fixes);
		string s;
		int unsigned n, k;
		logic [7:0] junk;
		for (n = 0; n < n_fixes; n++) begin
			s = random_sentence();
			case ($urandom_range(0, 9))
				0: begin
					k = $urandom_range(0, s.len() - 1);
					junk = $urandom_range(1, 255);
					s.putc(k, junk);
					queue_text(s);
				end
				1: queue_text(s.substr(0, $urandom_range(0, s.len() - 1)));
				2, 3, 4, 5, 6: queue_noise();
				default: queue_text(s);
			endcase
		end
	endfunction

	task automatic wait_drained();
		while (sentence_bytes.size() != 0 || expected_fixes.size() != 0 || push)
			@(negedge clk);
	endtask

	task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
		wait_drained();
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		string s;
		int unsigned i;
		clear_parser();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed sentences, no idling
		// largest magnitudes, south and west
		queue_text(",,,9999.99999,S,99999.99999,W,9999.999,999.999");
		// all zero, empty speed and course read as zero
		queue_text(",,,0000,N,00000,E,,");
		// missing longitude wins over a bad latitude character
		queue_text(",,,48x7,N,,E,1,2");
		// minute part without digits
		queue_text(",,,48,N,011,E");
		// lowercase south, a W past the saturated character position, and the
		// field count saturating past fifteen
		s = ",,,0100,s,00100,";
		for (i = 0; i < 32; i++)
			s = {s, "x"};
		queue_text({s, "W,,,,,,,,,,,"});
		// a lone comma and the byte extremes
		queue_text(",");
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hFF, 1'b1);

		set_idling(0, 0);
		queue_random(RAND_FIXES);
		set_idling(56, 0);
		queue_random(RAND_FIXES);
		set_idling(0, 56);
		queue_random(RAND_FIXES);
		set_idling(56, 56);
		queue_random(RAND_FIXES);
		set_idling(7, 7);
		queue_random(RAND_FIXES);

		// pressure: reader holds off while short sentences keep coming, so the
		// result queue, the pipeline and the middle queue fill and full rises
		set_idling(0, 0);
		hold_requests = hold_requests + 1;
		for (i = 0; i < 12; i++) begin
			if (i % 6 == 0)
				queue_text({",,,", angle_text(LAT_DEG_DIGITS), ",S,",
					angle_text(LON_DEG_DIGITS), ",W"});
			else
				queue_noise();
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
